### rtl/gamepad_input_conditioner_top_macros.svh
// Assertion helpers used by the conditioner core.
`ifndef GAMEPAD_INPUT_CONDITIONER_TOP_MACROS_SVH
`define GAMEPAD_INPUT_CONDITIONER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gic: implication check failed");

// Next-cycle implication, checked outside reset.
`define GIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gic: next-cycle check failed");

`endif

### rtl/gic_pkg.sv
`timescale 1ns / 1ps

package gic_pkg;

    localparam int SDATA_W    = 96;
    localparam int MDATA_W    = 144;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CSUB_W = 34;
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] TRG_LAST  = 4'd15;
    localparam logic [CNT_W-1:0] ROOT_LAST = 4'd15;
    localparam logic [CNT_W-1:0] QUO_LAST  = 4'd14;

    localparam logic [7:0]  TRG_MAX   = 8'd255;
    localparam logic [14:0] STICK_MAX = 15'd32767;
    localparam logic [31:0] ROOT_BIT0 = 32'h4000_0000;

    localparam logic [CFG_ADDR_W-1:0] CFG_TRG_DZ   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_DZ  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_DZ = 2'd2;

    localparam logic [7:0]  TRG_DZ_RST   = 8'd30;
    localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRG_START,
        ST_TRG_DIV,
        ST_STK_SQX,
        ST_STK_SQY,
        ST_STK_SUM,
        ST_STK_ROOT,
        ST_STK_CHK,
        ST_STK_DEN,
        ST_STK_ISSUE,
        ST_STK_NUM,
        ST_STK_QDIV,
        ST_FIN
    } gic_state_t;

    // Packed high to low: the first listed field of the request sits highest.
    typedef struct packed {
        logic [15:0] right_y;
        logic [15:0] right_x;
        logic [15:0] left_y;
        logic [15:0] left_x;
        logic [7:0]  right_trigger;
        logic [7:0]  left_trigger;
        logic [15:0] buttons;
    } gic_sample_t;

    typedef struct packed {
        logic [15:0] right_out_y;
        logic [15:0] right_out_x;
        logic [15:0] left_out_y;
        logic [15:0] left_out_x;
        logic [15:0] right_trigger_level;
        logic [15:0] left_trigger_level;
        logic [15:0] released_mask;
        logic [15:0] pressed_mask;
        logic [15:0] held_mask;
    } gic_result_t;

    typedef struct packed {
        logic [7:0]  trg_dz;
        logic [14:0] left_dz;
        logic [14:0] right_dz;
    } gic_cfg_t;

    typedef struct packed {
        logic ge;
        logic [CSUB_W-1:0] diff;
    } gic_csub_t;

endpackage

### rtl/gic_mul.sv
`timescale 1ns / 1ps

module gic_mul (
    input  logic                          aclk,
    input  logic [gic_pkg::MUL_W-1:0]     op_a,
    input  logic [gic_pkg::MUL_W-1:0]     op_b,
    output logic [gic_pkg::PROD_W-1:0]    prod
);

    logic [gic_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### rtl/gic_csub.sv
`timescale 1ns / 1ps

module gic_csub (
    input  logic [gic_pkg::CSUB_W-1:0] op_a,
    input  logic [gic_pkg::CSUB_W-1:0] op_b,
    output gic_pkg::gic_csub_t         res
);

    always_comb begin
        res.ge   = (op_a >= op_b);
        res.diff = op_a - op_b;
    end

endmodule

### rtl/gic_core.sv
`timescale 1ns / 1ps

`include "gamepad_input_conditioner_top_macros.svh"

module gic_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  gic_pkg::gic_sample_t sample,
    input  gic_pkg::gic_cfg_t    cfg,
    output logic                 in_ready,
    output logic                 done,
    input  logic                 ack,
    output gic_pkg::gic_result_t result
);

    gic_pkg::gic_state_t state_reg, state_next;

    logic [15:0]                prev_reg;
    logic                       sel_reg, sel_next;
    logic                       comp_reg, comp_next;
    logic [gic_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    gic_pkg::gic_sample_t       smp_reg;
    gic_pkg::gic_result_t       res_reg;
    logic [31:0]                r_reg;
    logic [15:0]                q_reg;
    logic [31:0]                acc_reg;
    logic [31:0]                root_reg;
    logic [31:0]                bit_reg;
    logic [30:0]                den_reg;

    logic [gic_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [gic_pkg::PROD_W-1:0] prod;
    logic [gic_pkg::CSUB_W-1:0] cs_a, cs_b;
    gic_pkg::gic_csub_t         cs;

    logic [7:0]  trg_v, trg_div;
    logic [15:0] stk_x, stk_y;
    logic [14:0] stk_dz, stk_span;
    logic [16:0] mag_x, mag_y, mag_c;
    logic        neg_x, neg_y, neg_c;
    logic [15:0] len, len_m_dz;

    logic        trg_skip, stk_skip, len_low, comp_early;
    logic        trg_done, stk_done, comp_done;
    logic        trg_we, chk_we, comp_we;
    logic [15:0] trg_val, chk_x_val, chk_y_val, comp_val;

    function automatic logic [16:0] mag17(input logic [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        mag17 = v[15] ? 17'(-ext) : ext;
    endfunction

    function automatic logic [15:0] apply_sign(input logic neg, input logic [14:0] q);
        logic [15:0] ext;
        ext = {1'b0, q};
        apply_sign = neg ? 16'(-ext) : ext;
    endfunction

    gic_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    gic_csub u_csub (
        .op_a (cs_a),
        .op_b (cs_b),
        .res  (cs)
    );

    // operand selection for the current sample side
    always_comb begin
        trg_v    = sel_reg ? smp_reg.right_trigger : smp_reg.left_trigger;
        trg_div  = 8'(gic_pkg::TRG_MAX - cfg.trg_dz);
        stk_x    = sel_reg ? smp_reg.right_x : smp_reg.left_x;
        stk_y    = sel_reg ? smp_reg.right_y : smp_reg.left_y;
        stk_dz   = sel_reg ? cfg.right_dz : cfg.left_dz;
        stk_span = 15'(gic_pkg::STICK_MAX - stk_dz);
        mag_x    = mag17(stk_x);
        mag_y    = mag17(stk_y);
        neg_x    = stk_x[15];
        neg_y    = !stk_y[15] && (stk_y != 16'd0);
        mag_c    = comp_reg ? mag_y : mag_x;
        neg_c    = comp_reg ? neg_y : neg_x;
        len      = root_reg[15:0];
        len_m_dz = 16'(len - {1'b0, stk_dz});
        len_low  = (len < {1'b0, stk_dz});
    end

    // datapath control
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        cs_a  = '0;
        cs_b  = '0;
        unique case (state_reg)
            gic_pkg::ST_STK_SQX: begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
            gic_pkg::ST_STK_SQY: begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            gic_pkg::ST_STK_CHK: begin
                mul_a = {2'b00, stk_span};
                mul_b = {1'b0, len};
            end
            gic_pkg::ST_STK_ISSUE: begin
                mul_a = mag_c;
                mul_b = {1'b0, len_m_dz};
            end
            gic_pkg::ST_TRG_DIV: begin
                cs_a = {25'd0, r_reg[7:0], 1'b0};
                cs_b = {26'd0, trg_div};
            end
            gic_pkg::ST_STK_ROOT: begin
                cs_a = {2'b00, acc_reg};
                cs_b = {1'b0, 33'(root_reg) + 33'(bit_reg)};
            end
            gic_pkg::ST_STK_NUM: begin
                cs_a = prod;
                cs_b = {3'b000, den_reg};
            end
            gic_pkg::ST_STK_QDIV: begin
                cs_a = {1'b0, r_reg, 1'b0};
                cs_b = {3'b000, den_reg};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        trg_skip   = (trg_v < cfg.trg_dz) || (trg_v == gic_pkg::TRG_MAX);
        stk_skip   = len_low || (stk_dz == gic_pkg::STICK_MAX);
        comp_early = (mag_c == 17'd0) || cs.ge;

        trg_we  = ((state_reg == gic_pkg::ST_TRG_START) && trg_skip)
               || ((state_reg == gic_pkg::ST_TRG_DIV) && (cnt_reg == gic_pkg::TRG_LAST));
        trg_val = (state_reg == gic_pkg::ST_TRG_DIV) ? {q_reg[14:0], cs.ge}
                : ((trg_v < cfg.trg_dz) ? 16'd0 : 16'hFFFF);

        chk_we    = (state_reg == gic_pkg::ST_STK_CHK) && stk_skip;
        chk_x_val = (len_low || (mag_x == 17'd0)) ? 16'd0
                  : apply_sign(neg_x, gic_pkg::STICK_MAX);
        chk_y_val = (len_low || (mag_y == 17'd0)) ? 16'd0
                  : apply_sign(neg_y, gic_pkg::STICK_MAX);

        comp_we  = ((state_reg == gic_pkg::ST_STK_NUM) && comp_early)
                || ((state_reg == gic_pkg::ST_STK_QDIV) && (cnt_reg == gic_pkg::QUO_LAST));
        if (state_reg == gic_pkg::ST_STK_QDIV) begin
            comp_val = apply_sign(neg_c, {q_reg[13:0], cs.ge});
        end else if (mag_c == 17'd0) begin
            comp_val = 16'd0;
        end else begin
            comp_val = apply_sign(neg_c, gic_pkg::STICK_MAX);
        end

        trg_done  = trg_we;
        comp_done = comp_we;
        stk_done  = chk_we || (comp_done && comp_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gic_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = gic_pkg::ST_TRG_START;
                end
            end
            gic_pkg::ST_TRG_START, gic_pkg::ST_TRG_DIV: begin
                if (trg_done) begin
                    state_next = sel_reg ? gic_pkg::ST_STK_SQX : gic_pkg::ST_TRG_START;
                end else begin
                    state_next = gic_pkg::ST_TRG_DIV;
                end
            end
            gic_pkg::ST_STK_SQX:  state_next = gic_pkg::ST_STK_SQY;
            gic_pkg::ST_STK_SQY:  state_next = gic_pkg::ST_STK_SUM;
            gic_pkg::ST_STK_SUM:  state_next = gic_pkg::ST_STK_ROOT;
            gic_pkg::ST_STK_ROOT: begin
                if (cnt_reg == gic_pkg::ROOT_LAST) begin
                    state_next = gic_pkg::ST_STK_CHK;
                end
            end
            gic_pkg::ST_STK_CHK: begin
                if (stk_done) begin
                    state_next = sel_reg ? gic_pkg::ST_FIN : gic_pkg::ST_STK_SQX;
                end else begin
                    state_next = gic_pkg::ST_STK_DEN;
                end
            end
            gic_pkg::ST_STK_DEN:   state_next = gic_pkg::ST_STK_ISSUE;
            gic_pkg::ST_STK_ISSUE: state_next = gic_pkg::ST_STK_NUM;
            gic_pkg::ST_STK_NUM, gic_pkg::ST_STK_QDIV: begin
                if (stk_done) begin
                    state_next = sel_reg ? gic_pkg::ST_FIN : gic_pkg::ST_STK_SQX;
                end else if (comp_done) begin
                    state_next = gic_pkg::ST_STK_ISSUE;
                end else begin
                    state_next = gic_pkg::ST_STK_QDIV;
                end
            end
            gic_pkg::ST_FIN: begin
                if (ack) begin
                    state_next = gic_pkg::ST_IDLE;
                end
            end
            default: state_next = gic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        sel_next  = (trg_done || stk_done) ? !sel_reg : sel_reg;
        comp_next = comp_done ? !comp_reg : comp_reg;
        if (((state_reg == gic_pkg::ST_TRG_DIV) && (cnt_reg != gic_pkg::TRG_LAST))
            || ((state_reg == gic_pkg::ST_STK_ROOT) && (cnt_reg != gic_pkg::ROOT_LAST))
            || ((state_reg == gic_pkg::ST_STK_QDIV) && (cnt_reg != gic_pkg::QUO_LAST))) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gic_pkg::ST_IDLE;
            prev_reg  <= '0;
            sel_reg   <= 1'b0;
            comp_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
            if (in_valid && in_ready) begin
                prev_reg <= sample.buttons;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            smp_reg               <= sample;
            res_reg.held_mask     <= sample.buttons;
            res_reg.pressed_mask  <= sample.buttons & ~prev_reg;
            res_reg.released_mask <= prev_reg & ~sample.buttons;
        end

        unique case (state_reg)
            gic_pkg::ST_TRG_START: begin
                r_reg <= {24'd0, 8'(trg_v - cfg.trg_dz)};
                q_reg <= '0;
            end
            gic_pkg::ST_TRG_DIV: begin
                r_reg <= cs.ge ? 32'(cs.diff) : {23'd0, r_reg[7:0], 1'b0};
                q_reg <= {q_reg[14:0], cs.ge};
            end
            gic_pkg::ST_STK_SQY: begin
                acc_reg <= prod[31:0];
            end
            gic_pkg::ST_STK_SUM: begin
                acc_reg  <= acc_reg + prod[31:0];
                root_reg <= '0;
                bit_reg  <= gic_pkg::ROOT_BIT0;
            end
            gic_pkg::ST_STK_ROOT: begin
                if (cs.ge) begin
                    acc_reg  <= 32'(cs.diff);
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            gic_pkg::ST_STK_DEN: begin
                den_reg <= prod[30:0];
            end
            gic_pkg::ST_STK_NUM: begin
                r_reg <= prod[31:0];
                q_reg <= '0;
            end
            gic_pkg::ST_STK_QDIV: begin
                r_reg <= cs.ge ? 32'(cs.diff) : {r_reg[30:0], 1'b0};
                q_reg <= {q_reg[14:0], cs.ge};
            end
            default: begin
            end
        endcase

        if (trg_we) begin
            if (sel_reg) begin
                res_reg.right_trigger_level <= trg_val;
            end else begin
                res_reg.left_trigger_level <= trg_val;
            end
        end

        if (chk_we) begin
            if (sel_reg) begin
                res_reg.right_out_x <= chk_x_val;
                res_reg.right_out_y <= chk_y_val;
            end else begin
                res_reg.left_out_x <= chk_x_val;
                res_reg.left_out_y <= chk_y_val;
            end
        end

        if (comp_we) begin
            unique case ({sel_reg, comp_reg})
                2'b00:   res_reg.left_out_x  <= comp_val;
                2'b01:   res_reg.left_out_y  <= comp_val;
                2'b10:   res_reg.right_out_x <= comp_val;
                default: res_reg.right_out_y <= comp_val;
            endcase
        end
    end

    assign in_ready = (state_reg == gic_pkg::ST_IDLE);
    assign done     = (state_reg == gic_pkg::ST_FIN);
    assign result   = res_reg;

    `GIC_ASSERT_NXT(a_accept_starts, aclk, aresetn, in_valid && in_ready, state_reg == gic_pkg::ST_TRG_START)
    `GIC_ASSERT_IMP(a_trg_rem_below_div, aclk, aresetn, state_reg == gic_pkg::ST_TRG_DIV, (r_reg[31:8] == 24'd0) && (r_reg[7:0] < trg_div))
    `GIC_ASSERT_IMP(a_quo_rem_below_den, aclk, aresetn, state_reg == gic_pkg::ST_STK_QDIV, r_reg < {1'b0, den_reg})
    `GIC_ASSERT_IMP(a_stick_no_min, aclk, aresetn, done, (res_reg.left_out_x != 16'h8000) && (res_reg.left_out_y != 16'h8000) && (res_reg.right_out_x != 16'h8000) && (res_reg.right_out_y != 16'h8000))

endmodule

### rtl/gamepad_input_conditioner_top.sv
`timescale 1ns / 1ps

// Channel  | Ports                           | Payload
// ---------+---------------------------------+------------------------------------------
// sample   | s_tvalid, s_tready, s_tdata     | buttons, triggers, raw stick positions
// result   | m_tvalid, m_tready, m_tdata     | button masks, trigger levels, stick outputs
// config   | cfg_wr_en, cfg_addr, cfg_wdata  | deadzones, written at once, no read-back
//
// One shared compare-subtract unit runs 16 steps per trigger divide, 16 per stick square
// root and 15 per stick component divide, and one shared 17x17 multiplier forms the
// squares and the divide operands. s_tready is high only while the sequencer is idle,
// which it enters in the cycle after a result moves to the output register once it is
// empty or being taken, so a stalled m_tready holds the result and, once the core is
// done, the next sample. Reset is synchronous; it clears the previous button word and
// loads the default deadzones.
module gamepad_input_conditioner_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // buttons[15:0], left_trigger[23:16], right_trigger[31:24], left_x[47:32],
    // left_y[63:48], right_x[79:64], right_y[95:80]
    input  logic [gic_pkg::SDATA_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // held_mask[15:0], pressed_mask[31:16], released_mask[47:32],
    // left_trigger_level[63:48], right_trigger_level[79:64], left_out_x[95:80],
    // left_out_y[111:96], right_out_x[127:112], right_out_y[143:128]
    output logic [gic_pkg::MDATA_W-1:0]       m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [gic_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gic_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    gic_pkg::gic_cfg_t    cfg_reg;
    gic_pkg::gic_sample_t sample;
    gic_pkg::gic_result_t core_result;
    logic                 core_ready, core_done, load;
    logic                 out_valid_reg;
    logic [gic_pkg::MDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trg_dz   <= gic_pkg::TRG_DZ_RST;
            cfg_reg.left_dz  <= gic_pkg::LEFT_DZ_RST;
            cfg_reg.right_dz <= gic_pkg::RIGHT_DZ_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gic_pkg::CFG_TRG_DZ:   cfg_reg.trg_dz   <= cfg_wdata[7:0];
                gic_pkg::CFG_LEFT_DZ:  cfg_reg.left_dz  <= cfg_wdata;
                gic_pkg::CFG_RIGHT_DZ: cfg_reg.right_dz <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign sample = gic_pkg::gic_sample_t'(s_tdata);

    gic_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .sample   (sample),
        .cfg      (cfg_reg),
        .in_ready (core_ready),
        .done     (core_done),
        .ack      (load),
        .result   (core_result)
    );

    assign load = core_done && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= core_result;
        end
    end

    assign s_tready = core_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
